[rtl/core/first_touch_page_tracker_defines.svh]
// ----------------------------------------------------------------------------
// first touch page tracker assertion macros
// shared property shapes for the concurrent checks in the tracker
// ----------------------------------------------------------------------------
`ifndef FIRST_TOUCH_PAGE_TRACKER_DEFINES_SVH
`define FIRST_TOUCH_PAGE_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FTPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ftpt_pkg.sv]
// ----------------------------------------------------------------------------
// ftpt_pkg
// types and codes shared by the first touch page tracker and its cells
// ----------------------------------------------------------------------------
`default_nettype none

package ftpt_pkg;

  localparam int unsigned PageW = 32;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_NOTE  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_NOT_ACTIVE     = 2'd1;
  localparam logic [1:0] ST_ALREADY_ACTIVE = 2'd2;
  localparam logic [1:0] ST_FULL           = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [PageW-1:0] page_id;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             must_save;
    logic [PageW-1:0] save_page;
  } out_t;

  // what one cell hands to its right neighbor
  typedef struct packed {
    logic [PageW-1:0] val;
    logic             mine;
    logic             vld;
  } link_t;

endpackage

`default_nettype wire

[rtl/core/first_touch_page_tracker.sv]
// ----------------------------------------------------------------------------
// first_touch_page_tracker
// sorted, duplicate-free set of pages touched in the open transaction
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request (action, page_id); out_valid/out_ready
//   carry one result (status, must_save, save_page) for every request.
//   cfg_we/cfg_wdata load original_page_count; write it only while idle.
//   A result is registered, appearing the cycle after its request is accepted.
//   Throughput: one request per cycle while the receiver keeps up. The set
//   is a row of SET_CAPACITY cells that all compare the id in parallel and
//   shift right by one on insert, so a whole request completes in the cycle it
//   is accepted. When the receiver stalls, the result is held in the output
//   register and in_ready drops until it is taken; a request can be accepted
//   in the same cycle that the waiting result leaves.
//   Reset (synchronous, rst_n low) empties the set, closes the transaction,
//   zeroes original_page_count and drops out_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module first_touch_page_tracker #(
  parameter int unsigned SET_CAPACITY = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire ftpt_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output ftpt_pkg::out_t                  out_data,
  input  wire logic                       cfg_we,
  input  wire logic [ftpt_pkg::PageW-1:0] cfg_wdata
);

  `include "first_touch_page_tracker_defines.svh"

  logic [ftpt_pkg::PageW-1:0] opc_r;
  logic                       active_r, active_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ftpt_pkg::out_t             out_r, out_nxt;

  ftpt_pkg::link_t            links [SET_CAPACITY+1];
  logic [SET_CAPACITY-1:0]    hit_vec;
  logic [SET_CAPACITY-1:0]    vld_vec;

  logic                       fire;
  logic                       is_begin, is_note, is_end;
  logic                       begin_ok, note_ok, end_ok;
  logic                       flush, ins_en;
  logic [ftpt_pkg::PageW-1:0] id;
  logic                       dup, full, need_ins, must_save;
  logic [1:0]                 status;

  assign in_ready  = ~out_valid_r | out_ready;
  assign fire      = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign is_begin = (in_data.action == ftpt_pkg::ACT_BEGIN);
  assign is_note  = (in_data.action == ftpt_pkg::ACT_NOTE);
  assign is_end   = (in_data.action == ftpt_pkg::ACT_END);
  assign begin_ok = is_begin & ~active_r;
  assign note_ok  = is_note & active_r;
  assign end_ok   = is_end & active_r;

  // begin and end both empty the set; begin then notes page 0 if below opc_r
  assign flush = fire & (begin_ok | end_ok);
  assign id    = is_begin ? '0 : in_data.page_id;

  assign dup       = |hit_vec;
  assign full      = vld_vec[SET_CAPACITY-1];
  assign need_ins  = (begin_ok | note_ok) & (id < opc_r) & ~dup;
  assign must_save = need_ins & ~(note_ok & full);
  assign ins_en    = fire & must_save;

  always_comb begin
    status = ftpt_pkg::ST_OK;
    if (is_begin && active_r) begin
      status = ftpt_pkg::ST_ALREADY_ACTIVE;
    end else if ((is_note || is_end) && !active_r) begin
      status = ftpt_pkg::ST_NOT_ACTIVE;
    end else if (note_ok && need_ins && full) begin
      status = ftpt_pkg::ST_FULL;
    end
  end

  always_comb begin
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = status;
      out_nxt.must_save = must_save;
      out_nxt.save_page = must_save ? id : '0;
      if (begin_ok) begin
        active_nxt = 1'b1;
      end else if (end_ok) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      opc_r       <= '0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        opc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // left end of the row: never shifts in
  assign links[0] = '0;

  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    ftpt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .flush  (flush),
      .ins_en (ins_en),
      .id     (id),
      .left   (links[i]),
      .right  (links[i+1]),
      .hit    (hit_vec[i]),
      .vld    (vld_vec[i])
    );
  end

  `FTPT_ASSERT_SAME(a_save_only_ok, out_valid_r && out_r.must_save, out_r.status == ftpt_pkg::ST_OK, "save with non-ok status")
  `FTPT_ASSERT_SAME(a_vld_packed, 1'b1, $onehot({1'b0, vld_vec} + 1'b1), "set entries not packed from slot 0")
  `FTPT_ASSERT_NEXT(a_end_closes, fire && end_ok, !active_r && vld_vec == '0, "end left set or active flag")
  `FTPT_ASSERT_SAME(a_full_real, fire && status == ftpt_pkg::ST_FULL, full && active_r, "full reported with room")

endmodule

`default_nettype wire

[rtl/core/ftpt_cell.sv]
// ----------------------------------------------------------------------------
// ftpt_cell
// one slot of the sorted page set: compares against the request id and
// either keeps its entry, takes the new id, or takes its left neighbor's entry
// ----------------------------------------------------------------------------
`default_nettype none

module ftpt_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          flush,
  input  wire logic                          ins_en,
  input  wire logic [ftpt_pkg::PageW-1:0]    id,
  input  wire ftpt_pkg::link_t               left,
  output ftpt_pkg::link_t                    right,
  output logic                               hit,
  output logic                               vld
);

  logic                       vld_r, vld_nxt;
  logic [ftpt_pkg::PageW-1:0] val_r, val_nxt;
  logic                       e_v;
  logic                       mine;

  // flush makes the slot look empty for this request
  assign e_v  = vld_r & ~flush;
  // insertion point is at or left of this slot
  assign mine = ~e_v | (val_r >= id);
  assign hit  = e_v & (val_r == id);
  assign vld  = vld_r;

  // val, mine, vld
  assign right = {val_r, mine, e_v};

  always_comb begin
    vld_nxt = e_v;
    val_nxt = val_r;
    if (ins_en && mine) begin
      if (left.mine) begin
        vld_nxt = left.vld;
        val_nxt = left.val;
      end else begin
        vld_nxt = 1'b1;
        val_nxt = id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
